// ----- hdl/ect_pkg.sv -----
// Shared types and constants for the encoder channel tuner.
// Used by ect_quad, ect_debounce and encoder_channel_tuner_unit; depends on nothing.
package ect_pkg;

	typedef enum logic [2:0] {
		REG_HOME     = 3'd0,
		REG_STEP     = 3'd1,
		REG_THRESH   = 3'd2,
		REG_REVERSE  = 3'd3,
		REG_DEBOUNCE = 3'd4
	} reg_idx_t;

	localparam logic [7:0] HOME_RESET     = 8'd147;
	localparam logic [3:0] STEP_RESET     = 4'd1;
	localparam logic [2:0] THRESH_RESET   = 3'd4;
	localparam logic       REVERSE_RESET  = 1'b0;
	localparam logic [7:0] DEBOUNCE_RESET = 8'd35;

	localparam logic [1:0] PHASE_IDLE = 2'b11;
	localparam logic [7:0] QUIET_MAX  = 8'hFF;
	localparam logic [5:0] TUNE_LOW   = 6'b010000;

	localparam logic signed [1:0] QUAD_TABLE [0:15] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef struct packed {
		logic hit;
		logic up;
	} detent_t;

endpackage

// ----- hdl/ect_quad.sv -----
// Quadrature decoder with detent accumulation for the encoder channel tuner.
// Depends on ect_pkg for the transition table and the detent_t struct.
module ect_quad (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            pin_a,
	input  logic            pin_b,
	input  logic [2:0]      detent_threshold,
	input  logic            reverse_direction,
	output ect_pkg::detent_t detent
);

	logic [1:0]        last_phase_q;
	logic signed [3:0] count_q;
	logic [1:0]        phase;
	logic              changed;
	logic signed [1:0] delta;
	logic signed [4:0] acc;
	logic signed [4:0] thr;

	always_comb begin
		phase   = {pin_a, pin_b};
		changed = (phase != last_phase_q);
		delta   = ect_pkg::QUAD_TABLE[{last_phase_q, phase}];
		acc     = 5'(count_q) + 5'(delta);
		thr     = (detent_threshold == 3'd0) ? 5'sd1 : $signed({2'b00, detent_threshold});
		detent.hit = changed && ((acc >= thr) || (acc <= -thr));
		detent.up  = (acc > 5'sd0) ^ reverse_direction;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= ect_pkg::PHASE_IDLE;
			count_q      <= 4'sd0;
		end else if (en && changed) begin
			last_phase_q <= phase;
			count_q      <= detent.hit ? 4'sd0 : acc[3:0];
		end
	end

endmodule

// ----- hdl/ect_debounce.sv -----
// Push button debouncer with press detection for the encoder channel tuner.
// Depends on ect_pkg for the saturation constant.
module ect_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       button_level,
	input  logic [7:0] debounce_ticks,
	output logic       press
);

	logic       stable_q;
	logic       previous_q;
	logic [7:0] quiet_q;
	logic [7:0] quiet_next;
	logic       take;

	always_comb begin
		if (button_level != previous_q) begin
			quiet_next = 8'd0;
		end else if (quiet_q == ect_pkg::QUIET_MAX) begin
			quiet_next = quiet_q;
		end else begin
			quiet_next = quiet_q + 8'd1;
		end
		take  = (quiet_next >= debounce_ticks) && (button_level != stable_q);
		press = take && !button_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b1;
			previous_q <= 1'b1;
			quiet_q    <= ect_pkg::QUIET_MAX;
		end else if (en) begin
			previous_q <= button_level;
			quiet_q    <= quiet_next;
			if (take) begin
				stable_q <= button_level;
			end
		end
	end

endmodule

// ----- hdl/encoder_channel_tuner_unit.sv -----
// Top level of the encoder channel tuner: register port, input stage and result stage.
// Depends on ect_pkg, ect_quad and ect_debounce.
//
//   Port group   Direction  Handshake            Contents
//   cfg          in/out     APB psel/penable     five tuning registers
//   in           in         in_valid/in_stall    pin_a, pin_b, button_level
//   out          out        out_valid/out_stall  channel, retune, tune_word, detent_direction
//
// One transaction is accepted every cycle while in_stall is low; it lands in the input register.
// The input register feeds the decoder, debouncer and channel clamp, which load the
// result register in the same cycle. A stalled result holds the input register and
// raises in_stall only while both stages are full. Reset clears the valid flags and loads the
// tuning registers, the decoder state and the channel with their reset values at once.
module encoder_channel_tuner_unit #(
	parameter int TOP_CHANNEL = 210
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              pin_a,
	input  logic              pin_b,
	input  logic              button_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        channel,
	output logic              retune,
	output logic [15:0]       tune_word,
	output logic signed [1:0] detent_direction
);

	localparam int         BAND_TOP_INT = (TOP_CHANNEL > 255) ? 255 : TOP_CHANNEL;
	localparam logic [7:0] BAND_TOP     = 8'(BAND_TOP_INT);
	localparam logic [7:0] CHANNEL_RESET =
		(ect_pkg::HOME_RESET > BAND_TOP) ? BAND_TOP : ect_pkg::HOME_RESET;

	logic [7:0] home_q;
	logic [3:0] step_q;
	logic [2:0] thresh_q;
	logic       reverse_q;
	logic [7:0] debounce_q;

	logic              valid_s1;
	logic              pin_a_s1;
	logic              pin_b_s1;
	logic              button_s1;
	logic              valid_s2;
	logic [7:0]        channel_s2;
	logic              retune_s2;
	logic signed [1:0] direction_s2;
	logic [7:0]        channel_q;

	logic              move;
	logic              en;
	logic              wr;
	ect_pkg::reg_idx_t idx;
	ect_pkg::detent_t  detent;
	logic              press;
	logic signed [9:0] sum;
	logic [7:0]        stepped;
	logic [7:0]        home_clamped;
	logic [7:0]        channel_next;
	logic signed [1:0] direction_next;

	assign pready = 1'b1;
	assign idx    = ect_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;

	always_comb begin
		case (idx)
			ect_pkg::REG_HOME:     prdata = {24'd0, home_q};
			ect_pkg::REG_STEP:     prdata = {28'd0, step_q};
			ect_pkg::REG_THRESH:   prdata = {29'd0, thresh_q};
			ect_pkg::REG_REVERSE:  prdata = {31'd0, reverse_q};
			ect_pkg::REG_DEBOUNCE: prdata = {24'd0, debounce_q};
			default:               prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q     <= ect_pkg::HOME_RESET;
			step_q     <= ect_pkg::STEP_RESET;
			thresh_q   <= ect_pkg::THRESH_RESET;
			reverse_q  <= ect_pkg::REVERSE_RESET;
			debounce_q <= ect_pkg::DEBOUNCE_RESET;
		end else if (wr) begin
			case (idx)
				ect_pkg::REG_HOME:     home_q     <= pwdata[7:0];
				ect_pkg::REG_STEP:     step_q     <= pwdata[3:0];
				ect_pkg::REG_THRESH:   thresh_q   <= pwdata[2:0];
				ect_pkg::REG_REVERSE:  reverse_q  <= pwdata[0];
				ect_pkg::REG_DEBOUNCE: debounce_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign move     = !valid_s2 || !out_stall;
	assign en       = valid_s1 && move;
	assign in_stall = valid_s1 && !move;

	ect_quad u_quad (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.pin_a             (pin_a_s1),
		.pin_b             (pin_b_s1),
		.detent_threshold  (thresh_q),
		.reverse_direction (reverse_q),
		.detent            (detent)
	);

	ect_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.button_level   (button_s1),
		.debounce_ticks (debounce_q),
		.press          (press)
	);

	always_comb begin
		if (detent.up) begin
			sum = $signed({2'b00, channel_q}) + $signed({6'd0, step_q});
		end else begin
			sum = $signed({2'b00, channel_q}) - $signed({6'd0, step_q});
		end
		if (sum < 10'sd0) begin
			stepped = 8'd0;
		end else if (sum > $signed({2'b00, BAND_TOP})) begin
			stepped = BAND_TOP;
		end else begin
			stepped = sum[7:0];
		end
		home_clamped = (home_q > BAND_TOP) ? BAND_TOP : home_q;
		if (press) begin
			channel_next = home_clamped;
		end else if (detent.hit) begin
			channel_next = stepped;
		end else begin
			channel_next = channel_q;
		end
		if (!detent.hit) begin
			direction_next = 2'sd0;
		end else if (detent.up) begin
			direction_next = 2'sd1;
		end else begin
			direction_next = -2'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			channel_q <= CHANNEL_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (move) begin
				valid_s2 <= valid_s1;
			end
			if (en) begin
				channel_q <= channel_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			pin_a_s1  <= pin_a;
			pin_b_s1  <= pin_b;
			button_s1 <= button_level;
		end
		if (en) begin
			channel_s2   <= channel_next;
			retune_s2    <= detent.hit || press;
			direction_s2 <= direction_next;
		end
	end

	assign out_valid        = valid_s2;
	assign channel          = channel_s2;
	assign retune           = retune_s2;
	assign tune_word        = {2'b00, channel_s2, ect_pkg::TUNE_LOW};
	assign detent_direction = direction_s2;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for encoder_channel_tuner_unit: directed table, then random encoder walks.
// Inputs step a behavioral tuner model; results are checked in order, table rows against the table.
// Depends on ect_pkg and the RTL of the unit only.
module tb_top;

	localparam int TOP_CH = 210;
	localparam int BAND_TOP = (TOP_CH > 255) ? 255 : TOP_CH;
	localparam logic [5:0] TUNE_FLAG = 6'b010000;
	localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
	localparam logic [1:0] UP_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [1:0] DN_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 400;

	typedef struct packed {
		logic [7:0]        ch;
		logic              rt;
		logic [15:0]       word;
		logic signed [1:0] dir;
	} tune_result_t;

	typedef struct {
		logic              is_cfg;
		ect_pkg::reg_idx_t idx;
		logic [7:0]        value;
		logic              a;
		logic              b;
		logic              btn;
		tune_result_t      want;
	} drill_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_a = 1'b1;
	logic pin_b = 1'b1;
	logic button_level = 1'b1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] channel;
	logic retune;
	logic [15:0] tune_word;
	logic signed [1:0] detent_direction;

	logic row_typed = 1'b0;
	tune_result_t row_expect = '0;
	logic calm = 1'b0;
	int hold_cycles = 0;
	logic mismatch_seen = 1'b0;
	int idle_cycles = 0;

	tune_result_t tuner_expect_q[$];
	drill_row_t drill_q[$];

	logic [7:0] cfg_home = ect_pkg::HOME_RESET;
	logic [3:0] cfg_step = ect_pkg::STEP_RESET;
	logic [2:0] cfg_thresh = ect_pkg::THRESH_RESET;
	logic cfg_reverse = ect_pkg::REVERSE_RESET;
	logic [7:0] cfg_debounce = ect_pkg::DEBOUNCE_RESET;

	logic [1:0] prev_phase = 2'b11;
	int quad_count = 0;
	logic [7:0] chan_now = 8'd147;
	logic btn_settled = 1'b1;
	logic btn_last = 1'b1;
	int quiet_ticks = 255;

	logic [1:0] walk_phase = 2'b11;
	int turn = 1;
	logic btn_goal = 1'b1;
	int bounce_left = 0;
	int hold_left = 0;

	encoder_channel_tuner_unit #(.TOP_CHANNEL(TOP_CH)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pin_a(pin_a), .pin_b(pin_b), .button_level(button_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel(channel), .retune(retune), .tune_word(tune_word),
		.detent_direction(detent_direction)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] tune_word_for(logic [7:0] ch);
		return {2'b00, ch, TUNE_FLAG};
	endfunction

	function automatic logic [7:0] clamp_channel(int v);
		if (v < 0) return 8'd0;
		if (v > BAND_TOP) return BAND_TOP[7:0];
		return v[7:0];
	endfunction

	function automatic tune_result_t make_result(logic [7:0] ch, logic rt, logic signed [1:0] dir);
		tune_result_t r;
		r.ch = ch;
		r.rt = rt;
		r.word = tune_word_for(ch);
		r.dir = dir;
		return r;
	endfunction

	task automatic advance_tuner(input logic a, input logic b, input logic btn,
			output tune_result_t r);
		logic [1:0] ph;
		int acc;
		int thr;
		int d;
		logic rt;
		ph = {a, b};
		d = 0;
		rt = 1'b0;
		if (ph != prev_phase) begin
			acc = quad_count + QUAD_STEP[{prev_phase, ph}];
			thr = (cfg_thresh == 3'd0) ? 1 : int'(cfg_thresh);
			prev_phase = ph;
			if (acc >= thr || acc <= -thr) begin
				d = (acc > 0) ? 1 : -1;
				if (cfg_reverse) d = -d;
				acc = 0;
				chan_now = clamp_channel(int'(chan_now) + d * int'(cfg_step));
				rt = 1'b1;
			end
			quad_count = acc;
		end
		if (btn != btn_last) begin
			btn_last = btn;
			quiet_ticks = 0;
		end else if (quiet_ticks < 255) begin
			quiet_ticks++;
		end
		if (quiet_ticks >= int'(cfg_debounce) && btn != btn_settled) begin
			btn_settled = btn;
			if (!btn) begin
				chan_now = clamp_channel(int'(cfg_home));
				rt = 1'b1;
			end
		end
		r = make_result(chan_now, rt, 2'(d));
	endtask

	always @(posedge clk) begin : monitor
		tune_result_t got;
		tune_result_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (tuner_expect_q.size() == 0) begin
					$error("result transaction with no expectation: channel %0d", channel);
					mismatch_seen = 1'b1;
				end else begin
					want = tuner_expect_q.pop_front();
					if (channel !== want.ch) begin
						$error("channel: expected %0d, actual %0d", want.ch, channel);
						mismatch_seen = 1'b1;
					end
					if (retune !== want.rt) begin
						$error("retune: expected %0d, actual %0d", want.rt, retune);
						mismatch_seen = 1'b1;
					end
					if (tune_word !== want.word) begin
						$error("tune_word: expected %h, actual %h", want.word, tune_word);
						mismatch_seen = 1'b1;
					end
					if (detent_direction !== want.dir) begin
						$error("detent_direction: expected %0d, actual %0d", want.dir,
							detent_direction);
						mismatch_seen = 1'b1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				advance_tuner(pin_a, pin_b, button_level, got);
				if (row_typed) got = row_expect;
				tuner_expect_q.push_back(got);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 31);
		end
	end

	task automatic send_sample(input logic a, input logic b, input logic btn, input logic typed,
			input tune_result_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pin_a <= a;
		pin_b <= b;
		button_level <= btn;
		row_typed <= typed;
		row_expect <= want;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tuner_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input ect_pkg::reg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ect_pkg::REG_HOME: cfg_home = val;
			ect_pkg::REG_STEP: cfg_step = val[3:0];
			ect_pkg::REG_THRESH: cfg_thresh = val[2:0];
			ect_pkg::REG_REVERSE: cfg_reverse = val[0];
			ect_pkg::REG_DEBOUNCE: cfg_debounce = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void add_cfg(ect_pkg::reg_idx_t idx, logic [7:0] val);
		drill_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.value = val;
		r.a = 1'b1;
		r.b = 1'b1;
		r.btn = 1'b1;
		r.want = '0;
		drill_q.push_back(r);
	endfunction

	function automatic void add_sample(logic a, logic b, logic btn, logic [7:0] ch, logic rt,
			logic signed [1:0] dir);
		drill_row_t r;
		r.is_cfg = 1'b0;
		r.idx = ect_pkg::REG_HOME;
		r.value = '0;
		r.a = a;
		r.b = b;
		r.btn = btn;
		r.want = make_result(ch, rt, dir);
		drill_q.push_back(r);
	endfunction

	task automatic run_phase(input logic [7:0] home, input logic [7:0] step,
			input logic [7:0] thresh, input logic [7:0] rev, input logic [7:0] deb,
			input int calm_items, input int hold_at);
		int r;
		logic btn;
		quiesce();
		write_reg(ect_pkg::REG_HOME, home);
		write_reg(ect_pkg::REG_STEP, step);
		write_reg(ect_pkg::REG_THRESH, thresh);
		write_reg(ect_pkg::REG_REVERSE, rev);
		write_reg(ect_pkg::REG_DEBOUNCE, deb);
		hold_left = 0;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			calm = (n < calm_items);
			if (n == hold_at) hold_cycles = 80;
			if ($urandom_range(99) < 8) turn = -turn;
			r = $urandom_range(99);
			if (r < 72) walk_phase = (turn > 0) ? UP_NEXT[walk_phase] : DN_NEXT[walk_phase];
			else if (r >= 88) walk_phase = 2'($urandom_range(3));
			if (bounce_left > 0) begin
				btn = 1'($urandom_range(1));
				bounce_left--;
			end else begin
				if (hold_left == 0) begin
					btn_goal = !btn_goal;
					bounce_left = $urandom_range(5);
					hold_left = $urandom_range(int'(cfg_debounce) + 20);
				end else begin
					hold_left--;
				end
				btn = btn_goal;
			end
			send_sample(walk_phase[1], walk_phase[0], btn, 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		add_sample(1'b1, 1'b1, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_sample(1'b0, 1'b1, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_sample(1'b0, 1'b0, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_sample(1'b1, 1'b0, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_sample(1'b1, 1'b1, 1'b1, 8'd148, 1'b1, 2'sd1);
		add_sample(1'b1, 1'b0, 1'b1, 8'd148, 1'b0, 2'sd0);
		add_sample(1'b0, 1'b0, 1'b1, 8'd148, 1'b0, 2'sd0);
		add_sample(1'b0, 1'b1, 1'b1, 8'd148, 1'b0, 2'sd0);
		add_sample(1'b1, 1'b1, 1'b1, 8'd147, 1'b1, -2'sd1);
		add_sample(1'b0, 1'b0, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_sample(1'b1, 1'b1, 1'b1, 8'd147, 1'b0, 2'sd0);
		add_cfg(ect_pkg::REG_DEBOUNCE, 8'd0);
		add_sample(1'b1, 1'b1, 1'b0, 8'd147, 1'b1, 2'sd0);
		add_cfg(ect_pkg::REG_HOME, 8'd255);
		add_cfg(ect_pkg::REG_STEP, 8'd15);
		add_cfg(ect_pkg::REG_THRESH, 8'd0);
		add_cfg(ect_pkg::REG_REVERSE, 8'd1);
		add_sample(1'b0, 1'b1, 1'b1, 8'd132, 1'b1, -2'sd1);
		add_sample(1'b0, 1'b0, 1'b0, 8'd210, 1'b1, -2'sd1);
		add_cfg(ect_pkg::REG_REVERSE, 8'd0);
		add_sample(1'b1, 1'b0, 1'b0, 8'd210, 1'b1, 2'sd1);
		add_cfg(ect_pkg::REG_HOME, 8'd0);
		add_sample(1'b1, 1'b0, 1'b1, 8'd210, 1'b0, 2'sd0);
		add_sample(1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 2'sd0);
		add_sample(1'b0, 1'b0, 1'b0, 8'd0, 1'b1, -2'sd1);
		add_cfg(ect_pkg::REG_STEP, 8'd0);
		add_sample(1'b0, 1'b1, 1'b0, 8'd0, 1'b1, -2'sd1);

		foreach (drill_q[i]) begin
			if (drill_q[i].is_cfg) begin
				quiesce();
				write_reg(drill_q[i].idx, drill_q[i].value);
			end else begin
				send_sample(drill_q[i].a, drill_q[i].b, drill_q[i].btn, 1'b1, drill_q[i].want);
			end
		end
		walk_phase = 2'b01;
		btn_goal = 1'b0;

		run_phase(8'd147, 8'd1, 8'd4, 8'd0, 8'd35, 0, -1);
		run_phase(8'd0, 8'd15, 8'd7, 8'd1, 8'd255, 0, 150);
		run_phase(8'd210, 8'd10, 8'd1, 8'd0, 8'd0, 200, -1);
		run_phase(8'd200, 8'd3, 8'd2, 8'd1, 8'd8, 0, 60);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(15)), 8'($urandom_range(7)),
			8'($urandom_range(1)), 8'($urandom_range(40)), 0, -1);

		quiesce();
		repeat (4) @(posedge clk);
		if (!mismatch_seen) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
